FILE: hdl/tsc_pkg.sv
// ----------------------------------------------------------------------------
// tsc_pkg: shared types, constants and tanh table for the soft clipper
// Register map, configuration bundle and the interpolation table built
// at elaboration.
// ----------------------------------------------------------------------------
package tsc_pkg;

	localparam int SAMPLE_BITS_DEF = 24;

	// table spans arguments [0, 8); must be a power of two
	localparam int TANH_TABLE_ENTRIES = 256;
	localparam int TAB_BITS = $clog2(TANH_TABLE_ENTRIES);
	localparam int TIDX_BITS = $clog2(TANH_TABLE_ENTRIES + 1);
	localparam int TH_BITS = 24;
	localparam int FRAC_T = 16;

	localparam int ADDR_BITS = 4;
	localparam int DATA_BITS = 32;

	localparam logic [1:0] REG_GAIN = 2'd0;
	localparam logic [1:0] REG_CEIL = 2'd1;
	localparam logic [1:0] REG_CLIP = 2'd2;

	localparam logic [22:0] GAIN_RST = 23'd138510;
	localparam logic [23:0] CEIL_RST = 24'd7919353;
	localparam logic CLIP_RST = 1'b1;
	localparam logic [23:0] CEIL_MIN = 24'd8;
	localparam logic [TH_BITS-1:0] TH_ONE = 24'h800000;

	// 16/N in Q4.31, the series argument for e^(-16/N)
	localparam longint unsigned TANH_XQ = (64'd1 << 35) / TANH_TABLE_ENTRIES;

	typedef struct packed {
		logic [22:0] gain;
		logic [23:0] ceiling;
		logic clip_en;
	} cfg_t;

	typedef logic [TANH_TABLE_ENTRIES:0][TH_BITS-1:0] tab_t;

	// shift-subtract quotient, truncated
	function automatic longint unsigned udiv64(input longint unsigned n,
		input longint unsigned d);
		longint unsigned q;
		longint unsigned r;
		q = 64'd0;
		r = 64'd0;
		for (int i = 63; i >= 0; i--) begin
			r = {r[62:0], n[i]};
			if (r >= d) begin
				r = r - d;
				q[i] = 1'b1;
			end
		end
		return q;
	endfunction

	// tanh(8i/N) = (1-t)/(1+t), t = e^(-16i/N) in Q0.31
	function automatic tab_t build_tanh_tab();
		tab_t tab;
		longint unsigned term;
		longint unsigned t;
		longint unsigned b;
		longint unsigned one;
		longint unsigned num;
		longint unsigned den;
		longint unsigned q;
		longint sum;
		term = 64'd1 << 31;
		one = term;
		t = term;
		sum = longint'(term);
		for (int k = 1; k <= 12; k++) begin
			term = udiv64((term * TANH_XQ) >> 31, 64'(k));
			if ((k & 1) == 1) begin
				sum = sum - longint'(term);
			end else begin
				sum = sum + longint'(term);
			end
		end
		b = (sum < 0) ? 64'd0 : longint'(sum);
		for (int k = 0; k <= TANH_TABLE_ENTRIES; k++) begin
			num = (t <= one) ? (one - t) : 64'd0;
			den = one + t;
			q = udiv64((num << 23) + (den >> 1), den);
			tab[k] = q[TH_BITS-1:0];
			t = (t * b + (64'd1 << 30)) >> 31;
		end
		return tab;
	endfunction

	localparam tab_t TANH_TAB = build_tanh_tab();

endpackage

FILE: hdl/tanh_soft_clipper.sv
// ----------------------------------------------------------------------------
// tanh_soft_clipper: ceiling * tanh(sample * gain) waveshaper
// Seven-stage pipeline: magnitude, gain multiply, table lookup,
// interpolation multiply, round, ceiling multiply, scale and saturate.
//
//  channel  | signals                           | role
//  ---------+-----------------------------------+---------------------------
//  in       | in_valid, in_ready, sample_in     | one sample word per item
//  out      | out_valid, out_ready, sample_out  | one shaped word per item
//  cfg      | psel..pwdata, prdata, pready      | APB, regs at 0x0/0x4/0x8
//
// One word per cycle sustained while out_ready allows; the pipe has seven
// register stages, three of them closing a multiplier.
// Reset clears stage valid bits and loads register defaults.
// A stalled output holds; each stage still fills while the one after it
// can move, so bubbles are squeezed out.
// ----------------------------------------------------------------------------
module tanh_soft_clipper #(
	parameter int SAMPLE_BITS = tsc_pkg::SAMPLE_BITS_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic psel,
	input  logic penable,
	input  logic pwrite,
	input  logic [tsc_pkg::ADDR_BITS-1:0] paddr,
	input  logic [tsc_pkg::DATA_BITS-1:0] pwdata,
	output logic [tsc_pkg::DATA_BITS-1:0] prdata,
	output logic pready,
	input  logic in_valid,
	output logic in_ready,
	input  logic signed [SAMPLE_BITS-1:0] sample_in,
	output logic out_valid,
	input  logic out_ready,
	output logic signed [SAMPLE_BITS-1:0] sample_out
);
	import tsc_pkg::*;

	localparam int S = SAMPLE_BITS;
	localparam int F = SAMPLE_BITS - 1;
	localparam int PW = SAMPLE_BITS + 23;
	localparam int POS_LSB = F + 3 - TAB_BITS;
	localparam int MW = 25 + ((F > 23) ? (F - 23) : 0);

	cfg_t cfg;

	tsc_regs u_regs (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.cfg(cfg)
	);

	assign pready = 1'b1;

	// stage valids and advance chain
	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7;
	logic [7:1] adv;

	assign adv[7] = !v_s7 || out_ready;
	assign adv[6] = !v_s6 || adv[7];
	assign adv[5] = !v_s5 || adv[6];
	assign adv[4] = !v_s4 || adv[5];
	assign adv[3] = !v_s3 || adv[4];
	assign adv[2] = !v_s2 || adv[3];
	assign adv[1] = !v_s1 || adv[2];
	assign in_ready = adv[1];
	assign out_valid = v_s7;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
		end else begin
			if (adv[1]) v_s1 <= in_valid;
			if (adv[2]) v_s2 <= v_s1;
			if (adv[3]) v_s3 <= v_s2;
			if (adv[4]) v_s4 <= v_s3;
			if (adv[5]) v_s5 <= v_s4;
			if (adv[6]) v_s6 <= v_s5;
			if (adv[7]) v_s7 <= v_s6;
		end
	end

	// side band carried along
	logic [S-1:0] raw_s1, raw_s2, raw_s3, raw_s4, raw_s5, raw_s6;
	logic neg_s1, neg_s2, neg_s3, neg_s4, neg_s5, neg_s6;
	logic en_s1, en_s2, en_s3, en_s4, en_s5, en_s6;

	// s1: magnitude
	logic [S-1:0] mag_s1;
	logic in_neg;
	assign in_neg = sample_in[S-1];

	// s2: p = |x| * gain
	logic [PW-1:0] p_s2;

	// s3: table lookup
	logic sat_s3;
	logic [TH_BITS-1:0] t0_s3, t1_s3;
	logic [FRAC_T-1:0] f_s3;
	logic [TAB_BITS-1:0] idx;
	logic [TIDX_BITS-1:0] idx0, idx1;
	assign idx = p_s2[F+18:F+19-TAB_BITS];
	assign idx0 = TIDX_BITS'(idx);
	assign idx1 = idx0 + TIDX_BITS'(1);

	// s4: slope * fraction
	logic signed [24:0] dif;
	logic signed [41:0] prod_s4;
	logic [TH_BITS-1:0] t0_s4;
	logic sat_s4;
	assign dif = $signed({1'b0, t1_s3}) - $signed({1'b0, t0_s3});

	// s5: rounded tanh
	logic signed [41:0] acc;
	logic [TH_BITS-1:0] th_s5;
	assign acc = $signed({2'b00, t0_s4, 16'h0000}) + prod_s4 + 42'sd32768;

	// s6: ceiling * tanh
	logic [23:0] ceil_c;
	logic [47:0] cm_s6;
	assign ceil_c = (cfg.ceiling < CEIL_MIN) ? CEIL_MIN : cfg.ceiling;

	// s7: round, scale, saturate, sign; raw sample when clipping is off
	logic [48:0] cm_rnd;
	logic [24:0] m0;
	logic [MW-1:0] m_sc, m_lim;
	logic [MW-1:0] lim;
	logic [S-1:0] res;
	logic [S-1:0] res_s7;

	assign cm_rnd = 49'(cm_s6) + 49'(1 << 22);
	assign m0 = cm_rnd[47:23];
	assign lim = MW'(1) << F;

	generate
		if (F >= 23) begin : g_up
			assign m_sc = MW'(m0) << (F - 23);
		end else begin : g_dn
			logic [25:0] m_rnd;
			assign m_rnd = 26'(m0) + 26'(1 << (22 - F));
			assign m_sc = MW'(m_rnd >> (23 - F));
		end
	endgenerate

	always_comb begin
		if (neg_s6) begin
			m_lim = (m_sc > lim) ? lim : m_sc;
			res = S'(MW'(0) - m_lim);
		end else begin
			m_lim = (m_sc > lim - MW'(1)) ? (lim - MW'(1)) : m_sc;
			res = S'(m_lim);
		end
		if (!en_s6) begin
			res = raw_s6;
		end
	end

	always_ff @(posedge clk) begin
		if (adv[1]) begin
			raw_s1 <= sample_in;
			neg_s1 <= in_neg;
			en_s1 <= cfg.clip_en;
			mag_s1 <= in_neg ? S'(S'(0) - sample_in) : sample_in;
		end
		if (adv[2]) begin
			raw_s2 <= raw_s1;
			neg_s2 <= neg_s1;
			en_s2 <= en_s1;
			p_s2 <= PW'(mag_s1) * PW'(cfg.gain);
		end
		if (adv[3]) begin
			raw_s3 <= raw_s2;
			neg_s3 <= neg_s2;
			en_s3 <= en_s2;
			sat_s3 <= |p_s2[PW-1:F+19];
			t0_s3 <= TANH_TAB[idx0];
			t1_s3 <= TANH_TAB[idx1];
			f_s3 <= p_s2[POS_LSB+FRAC_T-1:POS_LSB];
		end
		if (adv[4]) begin
			raw_s4 <= raw_s3;
			neg_s4 <= neg_s3;
			en_s4 <= en_s3;
			sat_s4 <= sat_s3;
			t0_s4 <= t0_s3;
			prod_s4 <= 42'(dif) * 42'($signed({1'b0, f_s3}));
		end
		if (adv[5]) begin
			raw_s5 <= raw_s4;
			neg_s5 <= neg_s4;
			en_s5 <= en_s4;
			th_s5 <= sat_s4 ? TH_ONE : acc[39:16];
		end
		if (adv[6]) begin
			raw_s6 <= raw_s5;
			neg_s6 <= neg_s5;
			en_s6 <= en_s5;
			cm_s6 <= 48'(ceil_c) * 48'(th_s5);
		end
		if (adv[7]) begin
			res_s7 <= res;
		end
	end

	assign sample_out = res_s7;

	// an empty output register lets the whole pipe take a word
	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("input stalled with empty output stage");

	a_bypass: assert property (@(posedge clk) disable iff (!arst_n)
		v_s6 && adv[7] && !en_s6 |=> sample_out == $past(raw_s6))
		else $error("bypass word altered");

	a_sign: assert property (@(posedge clk) disable iff (!arst_n)
		v_s6 && adv[7] && en_s6 && !neg_s6 |=> !sample_out[S-1])
		else $error("positive input gave negative output");

	a_table_mono: assert property (@(posedge clk) disable iff (!arst_n)
		v_s3 && !sat_s3 |-> t1_s3 >= t0_s3)
		else $error("tanh table not monotonic");

endmodule

FILE: hdl/tsc_regs.sv
// ----------------------------------------------------------------------------
// tsc_regs: APB register file of the soft clipper
// Holds drive gain, ceiling and clip enable; writes complete in the
// access phase, reads return the stored values.
// ----------------------------------------------------------------------------
module tsc_regs (
	input  logic clk,
	input  logic arst_n,
	input  logic psel,
	input  logic penable,
	input  logic pwrite,
	input  logic [tsc_pkg::ADDR_BITS-1:0] paddr,
	input  logic [tsc_pkg::DATA_BITS-1:0] pwdata,
	output logic [tsc_pkg::DATA_BITS-1:0] prdata,
	output tsc_pkg::cfg_t cfg
);
	import tsc_pkg::*;

	cfg_t cfg_q;
	logic [1:0] reg_sel;

	assign reg_sel = paddr[3:2];
	assign cfg = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.gain <= GAIN_RST;
			cfg_q.ceiling <= CEIL_RST;
			cfg_q.clip_en <= CLIP_RST;
		end else if (psel && penable && pwrite) begin
			case (reg_sel)
				REG_GAIN: cfg_q.gain <= pwdata[22:0];
				REG_CEIL: cfg_q.ceiling <= pwdata[23:0];
				REG_CLIP: cfg_q.clip_en <= pwdata[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_sel)
			REG_GAIN: prdata = DATA_BITS'(cfg_q.gain);
			REG_CEIL: prdata = DATA_BITS'(cfg_q.ceiling);
			REG_CLIP: prdata = DATA_BITS'(cfg_q.clip_en);
			default: prdata = '0;
		endcase
	end

endmodule
